// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== hdl/sdpr_pkg.sv =====
package sdpr_pkg;

    localparam int FIELD_W    = 86;
    localparam int TDATA_W    = 88;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_OFFSET  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_OFFSET = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LOW     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_HIGH    = 8'd3;

    localparam logic signed [7:0] CLAMP_LOW_RESET  = -8'sd128;
    localparam logic signed [7:0] CLAMP_HIGH_RESET = 8'sd127;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LSHIFT = 6'b000010,
        ST_MULT   = 6'b000100,
        ST_NORM   = 6'b001000,
        ST_RSHIFT = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    typedef struct packed {
        logic mac_en;
        logic start_sum;
        logic capture;
        logic lshift_en;
        logic mult_en;
        logic norm_en;
        logic rshift_en;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ===== hdl/s8_dot_product_requantize.sv =====
// Channel  Handshake                 Payload
// s_       s_tvalid / s_tready       s_tdata, s_tlast, s_tuser (element pair and channel data)
// m_       m_tvalid / m_tready       m_tdata, m_tlast (requantized byte)
// cfg_     cfg_valid / cfg_ready     cfg_index, cfg_data (register writes)
//
// While idle, the controller accepts one element without tlast per cycle.
// An element with tlast passes in order through accumulate, left shift,
// 32x32 multiply, rounding, right shift and clamp, each stage registered in the datapath.
// A full output register holds the clamp stage and blocks new input until taken.
// Reset restores the register defaults, empties the output and starts a new sum.
module s8_dot_product_requantize
    import sdpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] left_value, [15:8] right_value, [47:16] channel_bias,
    // [79:48] channel_multiplier, [85:80] channel_shift, [87:86] zero
    input  logic [TDATA_W-1:0]    s_tdata,
    input  logic                  s_tlast,
    // [0] last_output
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] out_value
    output logic [7:0]            m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    sdpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sdpr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_fields  (s_tdata[FIELD_W-1:0]),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== hdl/sdpr_ctrl.sv =====
`include "assert_macros.svh"

module sdpr_ctrl
    import sdpr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tlast,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   in_progress_reg;
    logic   in_progress_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            in_progress_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            in_progress_reg <= in_progress_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        in_progress_next = in_progress_reg;
        cmd              = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.mac_en    = 1'b1;
                    cmd.start_sum = !in_progress_reg;
                    if (s_tlast)
                    begin
                        cmd.capture      = 1'b1;
                        in_progress_next = 1'b0;
                        state_next       = ST_LSHIFT;
                    end
                    else
                    begin
                        in_progress_next = 1'b1;
                    end
                end
            end
            ST_LSHIFT:
            begin
                cmd.lshift_en = 1'b1;
                state_next    = ST_MULT;
            end
            ST_MULT:
            begin
                cmd.mult_en = 1'b1;
                state_next  = ST_NORM;
            end
            ST_NORM:
            begin
                cmd.norm_en = 1'b1;
                state_next  = ST_RSHIFT;
            end
            ST_RSHIFT:
            begin
                cmd.rshift_en = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the output register has room
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_last_starts_requant, clk, rst_n, s_tvalid && s_tready && s_tlast, state_reg == ST_LSHIFT)
    `ASSERT_NEXT(a_last_closes_sum, clk, rst_n, s_tvalid && s_tready && s_tlast, !in_progress_reg)
    `ASSERT_IMPL(a_load_needs_room, clk, rst_n, cmd.out_load, status.out_free)

endmodule

// ===== hdl/sdpr_datapath.sv =====
`include "assert_macros.svh"

module sdpr_datapath
    import sdpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    input  logic [FIELD_W-1:0]    s_fields,
    input  logic                  s_tuser,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic                  m_tlast
);

    logic signed [7:0]  left_value;
    logic signed [7:0]  right_value;
    logic        [31:0] channel_bias;
    logic signed [31:0] channel_multiplier;
    logic        [5:0]  channel_shift;

    logic signed [8:0] input_offset_reg;
    logic signed [7:0] output_offset_reg;
    logic signed [7:0] clamp_low_reg;
    logic signed [7:0] clamp_high_reg;

    logic        [31:0] acc_reg;
    logic signed [31:0] mult_reg;
    logic        [5:0]  shift_reg;
    logic               done_reg;
    logic        [31:0] x_reg;
    logic signed [63:0] prod64_reg;
    logic        [31:0] p_reg;
    logic        [31:0] r_sh_reg;
    logic               round_reg;
    logic               m_tvalid_reg;
    logic        [7:0]  m_tdata_reg;
    logic               m_tlast_reg;

    logic signed [9:0]  left_adj;
    logic signed [17:0] mac_prod;
    logic        [31:0] acc_base;
    logic        [31:0] acc_next;
    logic        [4:0]  lshift_amt;
    logic signed [63:0] norm_sum;
    logic        [5:0]  rshift_amt;
    logic signed [32:0] p_ext;
    logic signed [32:0] r_full;
    logic        [32:0] rem_mask;
    logic        [32:0] rem_val;
    logic        [32:0] rem_thr;
    logic signed [31:0] res_sum;
    logic signed [31:0] res_lo;
    logic signed [31:0] res_clamped;
    logic signed [31:0] clamp_low_ext;
    logic signed [31:0] clamp_high_ext;

    assign left_value         = s_fields[7:0];
    assign right_value        = s_fields[15:8];
    assign channel_bias       = s_fields[47:16];
    assign channel_multiplier = s_fields[79:48];
    assign channel_shift      = s_fields[85:80];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_offset_reg  <= '0;
            output_offset_reg <= '0;
            clamp_low_reg     <= CLAMP_LOW_RESET;
            clamp_high_reg    <= CLAMP_HIGH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_INPUT_OFFSET:  input_offset_reg  <= cfg_data;
                REG_OUTPUT_OFFSET: output_offset_reg <= cfg_data[7:0];
                REG_CLAMP_LOW:     clamp_low_reg     <= cfg_data[7:0];
                REG_CLAMP_HIGH:    clamp_high_reg    <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    assign left_adj = 10'(left_value) + 10'(input_offset_reg);
    assign mac_prod = left_adj * right_value;
    assign acc_base = cmd.start_sum ? channel_bias : acc_reg;
    assign acc_next = acc_base + 32'(mac_prod);

    assign lshift_amt = shift_reg[5] ? 5'd0 : shift_reg[4:0];
    assign norm_sum   = prod64_reg + 64'sd1073741824;
    assign rshift_amt = shift_reg[5] ? 6'(-shift_reg) : 6'd0;
    assign p_ext      = 33'(signed'(p_reg));
    assign r_full     = p_ext >>> rshift_amt;
    assign rem_mask   = (33'd1 << rshift_amt) - 33'd1;
    assign rem_val    = p_ext & rem_mask;
    assign rem_thr    = (rem_mask >> 1) + {32'd0, r_full[32]};

    assign clamp_low_ext  = 32'(clamp_low_reg);
    assign clamp_high_ext = 32'(clamp_high_reg);
    assign res_sum        = signed'(r_sh_reg + {31'd0, round_reg} + 32'(output_offset_reg));
    assign res_lo         = (res_sum < clamp_low_ext) ? clamp_low_ext : res_sum;
    assign res_clamped    = (res_lo > clamp_high_ext) ? clamp_high_ext : res_lo;

    always_ff @(posedge clk)
    begin
        if (cmd.mac_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.capture)
        begin
            mult_reg  <= channel_multiplier;
            shift_reg <= channel_shift;
            done_reg  <= s_tuser;
        end
        if (cmd.lshift_en)
        begin
            x_reg <= acc_reg << lshift_amt;
        end
        if (cmd.mult_en)
        begin
            prod64_reg <= signed'(x_reg) * mult_reg;
        end
        if (cmd.norm_en)
        begin
            p_reg <= norm_sum[62:31];
        end
        if (cmd.rshift_en)
        begin
            r_sh_reg  <= r_full[31:0];
            round_reg <= (rem_val > rem_thr);
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= res_clamped[7:0];
            m_tlast_reg <= done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign m_tlast         = m_tlast_reg;

    `ASSERT_NEXT(a_load_shows_result, clk, rst_n, cmd.out_load, m_tvalid)

endmodule
